FILE: rtl/psl_pkg.sv
// Package for the partitioned size-aware LRU block: request, result and queue types.
// Shared by psl_front, psl_back and partitioned_size_aware_lru; no dependencies.
package psl_pkg;

  localparam int unsigned DefPartitions = 4;
  localparam int unsigned DefSlotsPerPartition = 64;
  localparam logic [31:0] CapacityReset = 32'd1048576;

  typedef struct packed {
    logic [31:0] object_key;
    logic [23:0] object_size;
    logic [23:0] fragment_size;
    logic [1:0]  partition_index;
    logic        warming_up;
  } psl_req_t;

  typedef struct packed {
    logic        hit;
    logic        resized;
    logic        stored;
    logic [6:0]  evictions;
    logic [31:0] evict_bytes;
    logic [31:0] partition_fill;
    logic [47:0] hits_total;
    logic [47:0] accesses_total;
    logic [33:0] cached_total;
    logic [47:0] evicted_items_total;
    logic [55:0] evicted_bytes_total;
  } psl_rsp_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic     valid;
    psl_req_t item;
  } psl_q_t;

endpackage

FILE: rtl/partitioned_size_aware_lru.sv
// Top level of the partitioned size-aware LRU: capacity register, front queue, back sequencer.
// Depends on psl_pkg, psl_front, psl_back (and psl_ram through psl_back).
//
//  port group              dir  handshake
//  start / req_i           in   transfer when start && !busy
//  result_valid_o / rsp_o  out  one-cycle strobe, always taken
//  cfg_we_i / cfg_wdata_i  in   capacity written when cfg_we_i
//
// A request scans the partition's slots in order (the lookup walks them
// through the payload RAM's one read port), then moves a hit to the front,
// drops and reinserts a resized entry, or refuses or inserts, evicting tail
// entries as needed; a queued request also waits for the one ahead.
// Reset clears valid bits, list heads, fill levels and totals at once; no sweep.
// The two-entry request queue raises busy when full; results cannot be stalled.
module partitioned_size_aware_lru #(
  parameter int unsigned PARTITIONS          = psl_pkg::DefPartitions,
  parameter int unsigned SLOTS_PER_PARTITION = psl_pkg::DefSlotsPerPartition
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  psl_pkg::psl_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  output logic              result_valid_o,
  output psl_pkg::psl_rsp_t rsp_o
);
  import psl_pkg::*;

  logic [31:0] cap_q;
  psl_q_t      head;
  logic        pop;

  // Hold the partition capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  psl_front #(.PARTITIONS(PARTITIONS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .pop_i  (pop),
    .q_o    (head)
  );

  psl_back #(
    .PARTITIONS          (PARTITIONS),
    .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cap_i   (cap_q),
    .q_i     (head),
    .pop_o   (pop),
    .valid_o (result_valid_o),
    .rsp_o   (rsp_o)
  );

  // After an accepted transfer the queue head is valid next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> head.valid)
    else $error("accepted request missing from queue");

  // No result strobe directly follows another
  a_result_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // A hit neither resizes nor evicts
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.hit |-> rsp_o.stored && !rsp_o.resized && rsp_o.evictions == 7'd0)
    else $error("hit with resize or eviction");

endmodule

FILE: rtl/psl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psl_front.sv
// Front end: accepts requests, folds the partition index into range and queues them.
// Depends on psl_pkg.
module psl_front #(
  parameter int unsigned PARTITIONS = psl_pkg::DefPartitions
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  psl_pkg::psl_req_t req_i,
  input  logic              pop_i,
  output psl_pkg::psl_q_t   q_o
);
  import psl_pkg::*;

  logic [1:0] part_fold;
  psl_req_t   item_in;
  psl_req_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  // Fold the partition index modulo the partition count
  always_comb begin
    part_fold = req_i.partition_index;
    for (int k = 0; k < 3; k++) begin
      if (PARTITIONS < 4 && 32'(part_fold) >= PARTITIONS) begin
        part_fold = part_fold - 2'(PARTITIONS);
      end
    end
    item_in = req_i;
    item_in.partition_index = part_fold;
  end

  assign busy = (count_q == 2'd2);
  assign push = start && !busy;

  // Hold payload in a two-entry queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.item  = slot_q[rd_ptr_q];

endmodule

FILE: rtl/psl_back.sv
// Back end: sequencer that looks up, moves, evicts and inserts LRU entries.
// Depends on psl_pkg and psl_ram.
module psl_back #(
  parameter int unsigned PARTITIONS          = psl_pkg::DefPartitions,
  parameter int unsigned SLOTS_PER_PARTITION = psl_pkg::DefSlotsPerPartition
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       cap_i,
  input  psl_pkg::psl_q_t   q_i,
  output logic              pop_o,
  output logic              valid_o,
  output psl_pkg::psl_rsp_t rsp_o
);
  import psl_pkg::*;

  localparam int unsigned NSlot = PARTITIONS * SLOTS_PER_PARTITION;
  localparam int unsigned NW    = $clog2(NSlot);
  localparam int unsigned SW    = $clog2(SLOTS_PER_PARTITION);
  localparam int unsigned CW    = $clog2(SLOTS_PER_PARTITION + 1);
  localparam int unsigned PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int unsigned PayW  = 80;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CMP, S_RM_RD, S_RM_WR, S_PUSH_A, S_PUSH_B,
    S_EV_RD, S_EV_DO, S_INS, S_INS_CHK, S_INS_FREE, S_DONE
  } state_e;

  function automatic logic [NW-1:0] slot_addr(input logic [PW-1:0] p,
                                               input logic [SW-1:0] s);
    logic [NW:0] a;
    a = (NW+1)'(p) * (NW+1)'(SLOTS_PER_PARTITION) + (NW+1)'(s);
    return a[NW-1:0];
  endfunction

  state_e        state_q, ret_q;
  logic [31:0]   key_q;
  logic [23:0]   size_q, frag_q;
  logic [PW-1:0] part_q;
  logic          warm_q;
  logic [SW-1:0] idx_q, tgt_q;
  logic          hit_q, res_q, stored_q;
  logic [6:0]    ev_q;
  logic [31:0]   evb_q;
  logic [SW-1:0] front_q [PARTITIONS];
  logic [SW-1:0] back_q  [PARTITIONS];
  logic [31:0]   fill_q  [PARTITIONS];
  logic [CW-1:0] cnt_q   [PARTITIONS];
  logic [NSlot-1:0] valid_q;
  logic [47:0]   hits_q, acc_q, evi_q;
  logic [33:0]   cached_q;
  logic [55:0]   evbt_q;
  psl_rsp_t      rsp_q;
  logic          done_q;

  logic [SW-1:0] cur_front, cur_back;
  logic [31:0]   cur_fill;
  logic [CW-1:0] cur_cnt;
  logic [SLOTS_PER_PARTITION-1:0] pvalid;
  logic [SW-1:0] free_slot;
  logic [32:0]   need;

  logic [NW-1:0]   pay_raddr, pay_waddr;
  logic            pay_we;
  logic [PayW-1:0] pay_rdata;
  logic [31:0]     r_key;
  logic [23:0]     r_size, r_frag;
  logic [NW-1:0]   lnk_raddr, nw_waddr, ol_waddr;
  logic            nw_we, ol_we;
  logic [SW-1:0]   nw_wdata, ol_wdata, nw_rdata, ol_rdata;

  // Per-partition view
  assign cur_front = front_q[part_q];
  assign cur_back  = back_q[part_q];
  assign cur_fill  = fill_q[part_q];
  assign cur_cnt   = cnt_q[part_q];
  assign need      = {1'b0, cur_fill} + {9'b0, size_q};
  assign {r_key, r_size, r_frag} = pay_rdata;

  // Find the lowest free slot of the partition
  always_comb begin
    free_slot = '0;
    for (int i = 0; i < SLOTS_PER_PARTITION; i++) begin
      pvalid[i] = valid_q[slot_addr(part_q, SW'(i))];
    end
    for (int i = SLOTS_PER_PARTITION - 1; i >= 0; i--) begin
      if (!pvalid[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  // Entry payload: key, size and fragment
  assign pay_raddr = (state_q == S_EV_RD) ? slot_addr(part_q, cur_back)
                                          : slot_addr(part_q, idx_q);
  assign pay_we    = (state_q == S_INS_FREE);
  assign pay_waddr = slot_addr(part_q, free_slot);

  psl_ram #(.Width(PayW), .Depth(NSlot)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i ({key_q, size_q, frag_q}),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  // Link writes for unlink and push to front
  assign lnk_raddr = slot_addr(part_q, tgt_q);
  always_comb begin
    nw_we    = 1'b0;
    nw_waddr = slot_addr(part_q, tgt_q);
    nw_wdata = tgt_q;
    ol_we    = 1'b0;
    ol_waddr = slot_addr(part_q, tgt_q);
    ol_wdata = cur_front;
    case (state_q)
      S_RM_WR: begin
        nw_we    = (cur_back != tgt_q);
        nw_waddr = slot_addr(part_q, ol_rdata);
        nw_wdata = nw_rdata;
        ol_we    = (cur_front != tgt_q);
        ol_waddr = slot_addr(part_q, nw_rdata);
        ol_wdata = ol_rdata;
      end
      S_PUSH_A: begin
        nw_we = 1'b1;
        ol_we = 1'b1;
      end
      S_PUSH_B: begin
        nw_we    = (cur_cnt != '0);
        nw_waddr = slot_addr(part_q, cur_front);
      end
      default: ;
    endcase
  end

  psl_ram #(.Width(SW), .Depth(NSlot)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (nw_we),
    .waddr_i (nw_waddr),
    .wdata_i (nw_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (nw_rdata)
  );

  psl_ram #(.Width(SW), .Depth(NSlot)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (ol_we),
    .waddr_i (ol_waddr),
    .wdata_i (ol_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (ol_rdata)
  );

  assign pop_o = (state_q == S_IDLE) && q_i.valid;

  // Sequencer: state, list heads, fill levels, totals and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      valid_q  <= '0;
      for (int p = 0; p < PARTITIONS; p++) begin
        front_q[p] <= '0;
        back_q[p]  <= '0;
        fill_q[p]  <= '0;
        cnt_q[p]   <= '0;
      end
      hits_q   <= '0;
      acc_q    <= '0;
      evi_q    <= '0;
      cached_q <= '0;
      evbt_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_i.valid) begin
            key_q    <= q_i.item.object_key;
            size_q   <= q_i.item.object_size;
            frag_q   <= q_i.item.fragment_size;
            part_q   <= PW'(q_i.item.partition_index);
            warm_q   <= q_i.item.warming_up;
            hit_q    <= 1'b0;
            res_q    <= 1'b0;
            stored_q <= 1'b0;
            ev_q     <= '0;
            evb_q    <= '0;
            idx_q    <= '0;
            if (!q_i.item.warming_up) begin
              acc_q <= acc_q + 48'd1;
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pvalid[idx_q]) begin
            state_q <= S_CMP;
          end else if (idx_q == SW'(SLOTS_PER_PARTITION - 1)) begin
            state_q <= S_INS;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CMP: begin
          if (r_key == key_q) begin
            tgt_q   <= idx_q;
            state_q <= S_RM_RD;
            if (r_size == size_q && r_frag == frag_q) begin
              hit_q    <= 1'b1;
              stored_q <= 1'b1;
              if (!warm_q) begin
                hits_q <= hits_q + 48'd1;
              end
              ret_q <= S_PUSH_A;
            end else begin
              // Size or fragment mismatch: drop the old bytes, then reinsert
              res_q          <= 1'b1;
              fill_q[part_q] <= cur_fill - 32'(r_size);
              cached_q       <= cached_q - 34'(r_size);
              ret_q          <= S_INS;
            end
          end else if (idx_q == SW'(SLOTS_PER_PARTITION - 1)) begin
            state_q <= S_INS;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_RM_RD: state_q <= S_RM_WR;
        S_RM_WR: begin
          if (cur_front == tgt_q) begin
            front_q[part_q] <= ol_rdata;
          end
          if (cur_back == tgt_q) begin
            back_q[part_q] <= nw_rdata;
          end
          valid_q[slot_addr(part_q, tgt_q)] <= 1'b0;
          cnt_q[part_q] <= cur_cnt - 1'b1;
          state_q <= ret_q;
        end
        S_PUSH_A: state_q <= S_PUSH_B;
        S_PUSH_B: begin
          if (cur_cnt == '0) begin
            back_q[part_q] <= tgt_q;
          end
          front_q[part_q] <= tgt_q;
          valid_q[slot_addr(part_q, tgt_q)] <= 1'b1;
          cnt_q[part_q] <= cur_cnt + 1'b1;
          state_q <= S_DONE;
        end
        S_INS: begin
          // Refuse objects larger than a partition
          if ({8'b0, size_q} > cap_i) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if (need > {1'b0, cap_i} && cur_cnt != '0) begin
            state_q <= S_EV_RD;
          end else if (cur_cnt >= CW'(SLOTS_PER_PARTITION)) begin
            state_q <= S_EV_RD;
          end else begin
            state_q <= S_INS_FREE;
          end
        end
        S_EV_RD: state_q <= S_EV_DO;
        S_EV_DO: begin
          // Evict the tail entry and count it
          fill_q[part_q] <= cur_fill - 32'(r_size);
          cached_q       <= cached_q - 34'(r_size);
          ev_q           <= ev_q + 7'd1;
          evb_q          <= evb_q + 32'(r_size);
          evi_q          <= evi_q + 48'd1;
          evbt_q         <= evbt_q + 56'(r_size);
          tgt_q          <= cur_back;
          ret_q          <= S_INS_CHK;
          state_q        <= S_RM_RD;
        end
        S_INS_FREE: begin
          tgt_q          <= free_slot;
          fill_q[part_q] <= cur_fill + 32'(size_q);
          cached_q       <= cached_q + 34'(size_q);
          stored_q       <= 1'b1;
          state_q        <= S_PUSH_A;
        end
        S_DONE: begin
          rsp_q.hit                 <= hit_q;
          rsp_q.resized             <= res_q;
          rsp_q.stored              <= stored_q;
          rsp_q.evictions           <= ev_q;
          rsp_q.evict_bytes         <= evb_q;
          rsp_q.partition_fill      <= cur_fill;
          rsp_q.hits_total          <= hits_q;
          rsp_q.accesses_total      <= acc_q;
          rsp_q.cached_total        <= cached_q;
          rsp_q.evicted_items_total <= evi_q;
          rsp_q.evicted_bytes_total <= evbt_q;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o = done_q;
  assign rsp_o   = rsp_q;

endmodule
